FILE: rtl/core/tspf_pkg.sv
// Shared types, codes and helper functions of the tabulated spline pair force block.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package tspf_pkg;

    typedef logic [2:0] t_status;

    localparam t_status ST_EVAL   = 3'd0;
    localparam t_status ST_LOAD   = 3'd1;
    localparam t_status ST_CUTOFF = 3'd2;
    localparam t_status ST_TABLE  = 3'd3;
    localparam t_status ST_ZERO   = 3'd4;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CUTOFF_SQ     = 3'd0;
    localparam t_cfg_idx CFG_SPACING       = 3'd1;
    localparam t_cfg_idx CFG_INV_SPACING   = 3'd2;
    localparam t_cfg_idx CFG_TABLE_ENTRIES = 3'd3;
    localparam t_cfg_idx CFG_USE_CHARGES   = 3'd4;

    localparam logic KIND_LOAD = 1'b0;

    // Pipeline item: handshake payload plus values fixed on the way down.
    typedef struct packed {
        t_status         status;
        logic [9:0]      slot;
        logic [31:0]     sval;
        logic [31:0]     sforce;
        logic [2:0][23:0] disp;
        logic [31:0]     charge;
        logic [23:0]     root;
        logic [15:0]     eps;
        logic            last;
        logic [47:0]     energy;
        logic [2:0]      fneg;
    } t_item;

    function automatic logic [47:0] abs48(input logic [47:0] v);
        return v[47] ? 48'(~v + 48'd1) : v;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

    function automatic logic [23:0] abs24(input logic [23:0] v);
        return v[23] ? 24'(~v + 24'd1) : v;
    endfunction

    // Apply sign to a magnitude and clamp to the signed 48-bit range.
    function automatic logic [47:0] sat48(input logic [79:0] mag, input logic neg);
        logic [79:0] lim;
        logic [79:0] m;
        lim = neg ? 80'h8000_0000_0000 : 80'h7FFF_FFFF_FFFF;
        m   = (mag > lim) ? lim : mag;
        return neg ? 48'(~m + 80'd1) : m[47:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tabulated_spline_pair_force.sv
// Top level of the tabulated spline pair force block: pipeline, config registers, tables.
// Depends on tspf_pkg and tspf_ram.
`default_nettype none

// Tabulated pair force by cubic Hermite interpolation. Load transactions (tuser 0) write
// one potential/force sample into the tables; evaluate transactions (tuser 1) take a pair
// displacement and return pair energy and the force on the first atom in Q24.24, with a
// status in tuser. The datapath is one stall-together pipeline: a new transaction is
// accepted every cycle while the output side takes results. The pipeline depth is set
// mostly by the 24-stage square root (one root bit per stage) and the 48-stage divider by
// r (one quotient bit per stage, three lanes for x, y, z). The two tables are two copies
// of one 64-bit wide RAM (value in the low half, force in the high half) so that samples
// idx and idx+1 are read in the same cycle. Loads write the tables at the same pipeline
// stage where evaluates read them, so results always follow transaction order and no
// forwarding is needed. Table contents are undefined after reset; no clearing pass runs.
// Write configuration only while the pipeline is empty.
module tabulated_spline_pair_force #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata from bit 0 up: entry_index[10], sample_value[32], sample_force[32],
    // disp_x[24], disp_y[24], disp_z[24], charge_product[32], zero pad[6]
    input  wire logic [183:0] i_s_tdata,
    // tuser: kind (0 load, 1 evaluate)
    input  wire logic         i_s_tuser,
    // Result stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata from bit 0 up: pair_energy[48], force_x[48], force_y[48], force_z[48]
    output logic      [191:0] o_m_tdata,
    // tuser: status
    output logic      [2:0]   o_m_tuser,
    // Configuration write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [47:0]  i_cfg_data
);

    localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SQ_STEPS = 24;
    localparam int DV_STEPS = 48;

    // Stage numbering
    localparam int P_IN  = 0;
    localparam int P_SQR = 1;
    localparam int P_SUM = 2;
    localparam int P_RT0 = 3;
    localparam int P_T   = P_RT0 + SQ_STEPS;
    localparam int P_RD  = P_T + 1;
    localparam int P_PRD = P_RD + 1;
    localparam int P_CF  = P_PRD + 1;
    localparam int P_HE  = P_CF + 1;
    localparam int P_PA  = P_HE + 1;
    localparam int P_DE  = P_PA + 1;
    localparam int P_GP  = P_DE + 1;
    localparam int P_GT  = P_GP + 1;
    localparam int P_G   = P_GT + 1;
    localparam int P_QP  = P_G + 1;
    localparam int P_QT  = P_QP + 1;
    localparam int P_QS  = P_QT + 1;
    localparam int P_FP  = P_QS + 1;
    localparam int P_FN  = P_FP + 1;
    localparam int P_DV0 = P_FN + 1;
    localparam int P_OUT = P_DV0 + DV_STEPS;
    localparam int NST   = P_OUT + 1;

    // ---------------------------------------------------------------- configuration
    logic [47:0] r_cutoff_sq;
    logic [23:0] r_spacing;
    logic [31:0] r_inv_spacing;
    logic [10:0] r_table_entries;
    logic        r_use_charges;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq     <= '0;
            r_spacing       <= 24'd1;
            r_inv_spacing   <= 32'd65536;
            r_table_entries <= 11'd2;
            r_use_charges   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tspf_pkg::CFG_CUTOFF_SQ:     r_cutoff_sq     <= i_cfg_data;
                tspf_pkg::CFG_SPACING:       r_spacing       <= i_cfg_data[23:0];
                tspf_pkg::CFG_INV_SPACING:   r_inv_spacing   <= i_cfg_data[31:0];
                tspf_pkg::CFG_TABLE_ENTRIES: r_table_entries <= i_cfg_data[10:0];
                tspf_pkg::CFG_USE_CHARGES:   r_use_charges   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- pipeline control
    // The whole pipeline moves together; it holds only when the result waits.
    logic w_adv;
    assign w_adv      = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = w_adv;

    tspf_pkg::t_item r_it [NST];
    tspf_pkg::t_item n_it [NST];
    logic            r_vld [NST];
    logic            n_vld [NST];
    tspf_pkg::t_item w_in_item;

    always_comb begin
        w_in_item         = '0;
        w_in_item.status  = (i_s_tuser == tspf_pkg::KIND_LOAD) ? tspf_pkg::ST_LOAD
                                                                : tspf_pkg::ST_EVAL;
        w_in_item.slot    = i_s_tdata[9:0];
        w_in_item.sval    = i_s_tdata[41:10];
        w_in_item.sforce  = i_s_tdata[73:42];
        w_in_item.disp[0] = i_s_tdata[97:74];
        w_in_item.disp[1] = i_s_tdata[121:98];
        w_in_item.disp[2] = i_s_tdata[145:122];
        w_in_item.charge  = i_s_tdata[177:146];
    end

    // ---------------------------------------------------------------- distance squared
    logic [46:0] r_sq [3];
    logic [47:0] w_r2;
    logic [47:0] r_r2;

    assign w_r2 = 48'(r_sq[0]) + 48'(r_sq[1]) + 48'(r_sq[2]);

    // ---------------------------------------------------------------- square root
    logic [25:0] r_sq_rem  [SQ_STEPS];
    logic [23:0] r_sq_root [SQ_STEPS];
    logic [47:0] r_sq_x    [SQ_STEPS];
    logic [25:0] n_sq_rem  [SQ_STEPS];
    logic [23:0] n_sq_root [SQ_STEPS];
    logic [47:0] n_sq_x    [SQ_STEPS];

    always_comb begin
        logic [25:0] rem_in;
        logic [23:0] root_in;
        logic [47:0] x_in;
        logic [27:0] sh;
        logic [27:0] trial;
        for (int j = 0; j < SQ_STEPS; j++) begin
            rem_in  = (j == 0) ? '0    : r_sq_rem[(j == 0) ? 0 : j - 1];
            root_in = (j == 0) ? '0    : r_sq_root[(j == 0) ? 0 : j - 1];
            x_in    = (j == 0) ? r_r2  : r_sq_x[(j == 0) ? 0 : j - 1];
            sh      = {rem_in, x_in[47 - 2*j -: 2]};
            trial   = {2'b00, root_in, 2'b01};
            if (sh >= trial) begin
                n_sq_rem[j]  = 26'(sh - trial);
                n_sq_root[j] = {root_in[22:0], 1'b1};
            end else begin
                n_sq_rem[j]  = sh[25:0];
                n_sq_root[j] = {root_in[22:0], 1'b0};
            end
            n_sq_x[j] = x_in;
        end
    end

    // ---------------------------------------------------------------- index and table
    logic [55:0] r_t;
    logic [23:0] w_idx;
    logic [16:0] w_n;
    logic        w_beyond;
    logic        w_last;
    logic [23:0] w_idx1;
    logic [16:0] w_slot;
    logic        w_we;

    assign w_idx    = r_t[55:32];
    assign w_n      = (17'(r_table_entries) < 17'(TABLE_DEPTH)) ? 17'(r_table_entries)
                                                                 : 17'(TABLE_DEPTH);
    assign w_beyond = 25'(w_idx) >= 25'(w_n);
    assign w_last   = (25'(w_idx) + 25'd1) >= 25'(w_n);
    assign w_idx1   = w_idx + 24'd1;
    assign w_slot   = 17'(r_it[P_T].slot);
    // Loads write at the stage where evaluates read, keeping table order.
    assign w_we     = w_adv && r_vld[P_T] && (r_it[P_T].status == tspf_pkg::ST_LOAD)
                      && (w_slot < 17'(TABLE_DEPTH));

    logic [63:0] w_rd_a;
    logic [63:0] w_rd_b;

    tspf_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot[AW-1:0]),
        .i_wdata ({r_it[P_T].sforce, r_it[P_T].sval}),
        .i_re    (w_adv),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    tspf_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot[AW-1:0]),
        .i_wdata ({r_it[P_T].sforce, r_it[P_T].sval}),
        .i_re    (w_adv),
        .i_raddr (w_idx1[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    // ---------------------------------------------------------------- Hermite coefficients
    logic signed [31:0] w_v0, w_f0, w_v1, w_f1;
    logic signed [24:0] w_hh;
    logic signed [33:0] w_fs2;
    logic signed [32:0] w_fs1;

    assign w_v0  = $signed(w_rd_a[31:0]);
    assign w_f0  = $signed(w_rd_a[63:32]);
    assign w_v1  = $signed(w_rd_b[31:0]);
    assign w_f1  = $signed(w_rd_b[63:32]);
    assign w_hh  = $signed({1'b0, r_spacing});
    assign w_fs2 = 34'(w_f1) + (34'(w_f0) <<< 1);
    assign w_fs1 = 33'(w_f1) + 33'(w_f0);

    logic signed [56:0] r_f0h;
    logic signed [58:0] r_s2;
    logic signed [57:0] r_s1;
    logic signed [32:0] r_dv;
    logic signed [31:0] r_v0;

    logic signed [57:0] w_nf;
    logic signed [59:0] w_dv60;
    logic signed [59:0] w_gsum;
    logic signed [59:0] w_hsum;

    assign w_nf   = -(58'(r_f0h));
    assign w_dv60 = 60'(r_dv) <<< 24;
    assign w_gsum = w_dv60 * 60'sd3 + 60'(r_s2);
    assign w_hsum = -(w_dv60 <<< 1) - 60'(r_s1);

    logic signed [39:0] r_y;
    logic signed [41:0] r_f;
    logic signed [43:0] r_gc;
    logic signed [43:0] r_hc;

    // ---------------------------------------------------------------- Horner in eps
    logic signed [16:0] w_eps_he, w_eps_pa, w_eps_de;
    logic signed [60:0] w_peh;
    logic signed [44:0] w_a;
    logic signed [45:0] w_b;
    logic signed [61:0] w_pa;
    logic signed [62:0] w_pb;
    logic signed [63:0] w_pe;

    assign w_eps_he = $signed({1'b0, r_it[P_CF].eps});
    assign w_eps_pa = $signed({1'b0, r_it[P_HE].eps});
    assign w_eps_de = $signed({1'b0, r_it[P_PA].eps});
    assign w_peh    = w_eps_he * r_hc;

    logic signed [43:0] r_he;
    logic signed [39:0] r_y2, r_y3;
    logic signed [41:0] r_f2;
    logic signed [43:0] r_g2c;

    assign w_a  = 45'(r_g2c) + 45'(r_he);
    assign w_b  = 46'(r_g2c) + (46'(r_he) <<< 1);
    assign w_pa = w_eps_pa * w_a;
    assign w_pb = w_eps_pa * w_b;

    logic signed [46:0] r_p;
    logic signed [46:0] r_db;

    assign w_pe = w_eps_de * r_p;

    logic [47:0] r_d;
    logic [47:0] r_e;

    // ---------------------------------------------------------------- slope times 1/h
    logic [47:0] w_dmag;
    assign w_dmag = tspf_pkg::abs48(r_d);

    logic [55:0] r_gph, r_gpl;
    logic        r_gneg, r_gneg1;
    logic [47:0] r_e1, r_e2x, r_e3;
    logic [79:0] r_gtot;
    logic [47:0] r_g;

    // ---------------------------------------------------------------- charge scaling
    logic [31:0] w_qmag;
    logic [47:0] w_emag, w_gmag_q;

    assign w_qmag   = tspf_pkg::abs32(r_it[P_G].charge);
    assign w_emag   = tspf_pkg::abs48(r_e3);
    assign w_gmag_q = tspf_pkg::abs48(r_g);

    logic [55:0] r_qeh, r_qel, r_qgh, r_qgl;
    logic        r_qeneg, r_qgneg, r_qeneg1, r_qgneg1;
    logic [47:0] r_e4, r_g4, r_e5, r_g5;
    logic [79:0] r_qetot, r_qgtot;
    logic [47:0] r_e2, r_g2;

    // ---------------------------------------------------------------- force numerators
    logic [47:0] w_gmag;
    assign w_gmag = tspf_pkg::abs48(r_g2);

    logic [47:0] r_fph [3];
    logic [47:0] r_fpl [3];
    logic [71:0] r_fn  [3];

    // ---------------------------------------------------------------- divider by r
    logic [23:0] r_dv_rem [DV_STEPS][3];
    logic [71:0] r_dv_num [DV_STEPS][3];
    logic [47:0] r_dv_quo [DV_STEPS][3];
    logic [23:0] n_dv_rem [DV_STEPS][3];
    logic [71:0] n_dv_num [DV_STEPS][3];
    logic [47:0] n_dv_quo [DV_STEPS][3];

    always_comb begin
        logic [23:0] rem_in;
        logic [71:0] num_in;
        logic [47:0] quo_in;
        logic [23:0] root;
        logic [24:0] sh;
        logic        ge;
        for (int j = 0; j < DV_STEPS; j++) begin
            for (int k = 0; k < 3; k++) begin
                root   = r_it[P_FN + j].root;
                rem_in = (j == 0) ? r_fn[k][71:48] : r_dv_rem[(j == 0) ? 0 : j - 1][k];
                num_in = (j == 0) ? r_fn[k]        : r_dv_num[(j == 0) ? 0 : j - 1][k];
                quo_in = (j == 0) ? '0             : r_dv_quo[(j == 0) ? 0 : j - 1][k];
                sh     = {rem_in, num_in[DV_STEPS - 1 - j]};
                ge     = sh >= {1'b0, root};
                n_dv_rem[j][k] = ge ? 24'(sh - {1'b0, root}) : sh[23:0];
                n_dv_num[j][k] = num_in;
                n_dv_quo[j][k] = {quo_in[46:0], ge};
            end
        end
    end

    // ---------------------------------------------------------------- item shift and status
    always_comb begin
        n_it[0]  = w_in_item;
        n_vld[0] = i_s_tvalid;
        for (int k = 1; k < NST; k++) begin
            n_it[k]  = r_it[k-1];
            n_vld[k] = r_vld[k-1];
        end
        // Cutoff is checked before zero distance.
        if (r_it[P_SQR].status == tspf_pkg::ST_EVAL) begin
            if (w_r2 >= r_cutoff_sq) begin
                n_it[P_SUM].status = tspf_pkg::ST_CUTOFF;
            end else if (w_r2 == 48'd0) begin
                n_it[P_SUM].status = tspf_pkg::ST_ZERO;
            end
        end
        n_it[P_T].root = r_sq_root[SQ_STEPS-1];
        if ((r_it[P_T].status == tspf_pkg::ST_EVAL) && w_beyond) begin
            n_it[P_RD].status = tspf_pkg::ST_TABLE;
        end
        n_it[P_RD].last = w_last;
        n_it[P_RD].eps  = r_t[31:16];
        n_it[P_FP].energy = r_e2;
        for (int k = 0; k < 3; k++) begin
            // Force is minus g times d, so it is negative when both share a sign.
            n_it[P_FP].fneg[k] = (r_g2[47] == r_it[P_QS].disp[k][23]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            for (int k = 0; k < NST; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    // ---------------------------------------------------------------- datapath registers
    logic [47:0] r_out_energy;
    logic [47:0] r_out_force [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NST; k++) begin
                r_it[k] <= n_it[k];
            end

            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 47'(tspf_pkg::abs24(r_it[P_IN].disp[k])
                               * tspf_pkg::abs24(r_it[P_IN].disp[k]));
            end
            r_r2 <= w_r2;

            for (int j = 0; j < SQ_STEPS; j++) begin
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
                r_sq_x[j]    <= n_sq_x[j];
            end

            r_t <= 56'(r_sq_root[SQ_STEPS-1]) * 56'(r_inv_spacing);

            // Table data is valid while the item sits in the read stage.
            r_f0h <= w_f0 * w_hh;
            r_s2  <= w_fs2 * w_hh;
            r_s1  <= w_fs1 * w_hh;
            r_dv  <= 33'(w_v1) - 33'(w_v0);
            r_v0  <= w_v0;

            r_y  <= 40'(r_v0) <<< 8;
            r_f  <= w_nf[57:16];
            // Last sample in use has no following segment.
            r_gc <= r_it[P_PRD].last ? '0 : w_gsum[59:16];
            r_hc <= r_it[P_PRD].last ? '0 : w_hsum[59:16];

            r_he  <= w_peh[59:16];
            r_y2  <= r_y;
            r_f2  <= r_f;
            r_g2c <= r_gc;

            r_p  <= 47'(r_f2) + 47'($signed(w_pa[61:16]));
            r_db <= $signed(w_pb[62:16]);
            r_y3 <= r_y2;

            r_d <= 48'(r_p) + 48'(r_db);
            r_e <= 48'(r_y3) + $signed(w_pe[63:16]);

            r_gph  <= 56'(w_dmag[47:24]) * 56'(r_inv_spacing);
            r_gpl  <= 56'(w_dmag[23:0]) * 56'(r_inv_spacing);
            r_gneg <= r_d[47];
            r_e1   <= r_e;

            r_gtot  <= ({24'd0, r_gph} << 24) + 80'(r_gpl);
            r_gneg1 <= r_gneg;
            r_e2x   <= r_e1;

            r_g  <= tspf_pkg::sat48({16'd0, r_gtot[79:16]}, r_gneg1);
            r_e3 <= r_e2x;

            r_qeh   <= 56'(w_emag[47:24]) * 56'(w_qmag);
            r_qel   <= 56'(w_emag[23:0]) * 56'(w_qmag);
            r_qgh   <= 56'(w_gmag_q[47:24]) * 56'(w_qmag);
            r_qgl   <= 56'(w_gmag_q[23:0]) * 56'(w_qmag);
            r_qeneg <= r_e3[47] != r_it[P_G].charge[31];
            r_qgneg <= r_g[47] != r_it[P_G].charge[31];
            r_e4    <= r_e3;
            r_g4    <= r_g;

            r_qetot  <= ({24'd0, r_qeh} << 24) + 80'(r_qel);
            r_qgtot  <= ({24'd0, r_qgh} << 24) + 80'(r_qgl);
            r_qeneg1 <= r_qeneg;
            r_qgneg1 <= r_qgneg;
            r_e5     <= r_e4;
            r_g5     <= r_g4;

            r_e2 <= r_use_charges ? tspf_pkg::sat48({16'd0, r_qetot[79:16]}, r_qeneg1) : r_e5;
            r_g2 <= r_use_charges ? tspf_pkg::sat48({16'd0, r_qgtot[79:16]}, r_qgneg1) : r_g5;

            for (int k = 0; k < 3; k++) begin
                r_fph[k] <= 48'(w_gmag[47:24]) * 48'(tspf_pkg::abs24(r_it[P_QS].disp[k]));
                r_fpl[k] <= 48'(w_gmag[23:0]) * 48'(tspf_pkg::abs24(r_it[P_QS].disp[k]));
                r_fn[k]  <= ({24'd0, r_fph[k]} << 24) + 72'(r_fpl[k]);
            end

            for (int j = 0; j < DV_STEPS; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_dv_rem[j][k] <= n_dv_rem[j][k];
                    r_dv_num[j][k] <= n_dv_num[j][k];
                    r_dv_quo[j][k] <= n_dv_quo[j][k];
                end
            end

            // Drop the payload of anything but a successful evaluation.
            if (r_it[P_OUT-1].status == tspf_pkg::ST_EVAL) begin
                r_out_energy <= r_it[P_OUT-1].energy;
                for (int k = 0; k < 3; k++) begin
                    r_out_force[k] <= tspf_pkg::sat48({32'd0, r_dv_quo[DV_STEPS-1][k]},
                                                      r_it[P_OUT-1].fneg[k]);
                end
            end else begin
                r_out_energy <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_out_force[k] <= '0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result port
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tuser  = r_it[NST-1].status;
    assign o_m_tdata  = {r_out_force[2], r_out_force[1], r_out_force[0], r_out_energy};

endmodule

`default_nettype wire

FILE: rtl/core/tspf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tspf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
